// ===== hdl/mnep_pkg.sv =====
// Shared types, constants and helper functions of the MIDI note event parser.
`timescale 1ns / 1ps
`default_nettype none
package mnep_pkg;

	localparam int TRACK_START = 22;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [23:0] TEMPO_RESET = 24'd500000;
	localparam logic [15:0] TICK_SCALE = 16'd50000;

	typedef struct packed {
		logic        kind;
		logic [3:0]  channel;
		logic [7:0]  note_key;
		logic [7:0]  velocity;
		logic [1:0]  instrument;
		logic [27:0] delta;
		logic [23:0] tempo;
		logic [15:0] quarter;
		logic        seen;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'd77;
			2'd1: r = 8'd84;
			2'd2: r = 8'd104;
			default: r = 8'd100;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] key_div12(input logic [7:0] key);
		logic [15:0] p;
		p = 16'(key) * 16'd171;
		return p[15:11];
	endfunction

	function automatic logic [3:0] key_mod12(input logic [7:0] key);
		logic [7:0] d;
		d = 8'(key_div12(key)) * 8'd12;
		return 4'(key - d);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/mnep_file_if.sv =====
// Item channel that carries file bytes into the parser.
`timescale 1ns / 1ps
`default_nettype none
interface mnep_file_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       start_of_file;
	modport source (output valid, output file_byte, output start_of_file, input ready);
	modport sink (input valid, input file_byte, input start_of_file, output ready);
endinterface
`default_nettype wire

// ===== hdl/mnep_note_if.sv =====
// Item channel that carries note events out of the parser.
`timescale 1ns / 1ps
`default_nettype none
interface mnep_note_if #(parameter int WAIT_WIDTH = 16);
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [3:0]            channel;
	logic [7:0]            note_key;
	logic [7:0]            velocity;
	logic [3:0]            pitch_class;
	logic signed [5:0]     octave;
	logic [1:0]            instrument;
	logic [WAIT_WIDTH-1:0] wait_ticks;
	logic                  wait_saturated;
	logic                  joins_chord;
	modport source (output valid, output kind, output channel, output note_key,
		output velocity, output pitch_class, output octave, output instrument,
		output wait_ticks, output wait_saturated, output joins_chord, input ready);
	modport sink (input valid, input kind, input channel, input note_key,
		input velocity, input pitch_class, input octave, input instrument,
		input wait_ticks, input wait_saturated, input joins_chord, output ready);
endinterface
`default_nettype wire

// ===== hdl/mnep_front.sv =====
// Byte parser that walks the file header and track events and issues note jobs.
`timescale 1ns / 1ps
`default_nettype none
module mnep_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    file_byte,
	input  wire logic          start_of_file,
	output mnep_pkg::job_t     job,
	output logic               push
);
	localparam logic [3:0] PH_HEADER = 4'd0;
	localparam logic [3:0] PH_DONE = 4'd1;
	localparam logic [3:0] PH_DELTA = 4'd2;
	localparam logic [3:0] PH_STATUS = 4'd3;
	localparam logic [3:0] PH_META_TYPE = 4'd4;
	localparam logic [3:0] PH_META_LEN = 4'd5;
	localparam logic [3:0] PH_META_D0 = 4'd6;
	localparam logic [3:0] PH_META_D1 = 4'd7;
	localparam logic [3:0] PH_META_D2 = 4'd8;
	localparam logic [3:0] PH_SKIP = 4'd9;
	localparam logic [3:0] PH_PROGRAM = 4'd10;
	localparam logic [3:0] PH_NOTE_KEY = 4'd11;
	localparam logic [3:0] PH_NOTE_VEL = 4'd12;
	localparam logic [4:0] HDR_LAST = 5'(mnep_pkg::TRACK_START - 1);

	logic [4:0]  hidx_q, n_hidx;
	logic        mok_q, n_mok;
	logic [15:0] qt_q, n_qt;
	logic [23:0] tempo_q, n_tempo;
	logic [3:0]  ph_q, n_ph;
	logic [27:0] delta_q, n_delta;
	logic [7:0]  st_q, n_st;
	logic [7:0]  mt_q, n_mt;
	logic [7:0]  skip_q, n_skip;
	logic [23:0] tsh_q, n_tsh;
	logic [7:0]  key_q, n_key;
	logic [15:0] synth_q, n_synth;
	logic        seen_q, n_seen;
	logic        emit;
	mnep_pkg::job_t j;

	always_comb begin
		n_hidx = hidx_q; n_mok = mok_q; n_qt = qt_q; n_tempo = tempo_q;
		n_ph = ph_q; n_delta = delta_q; n_st = st_q; n_mt = mt_q;
		n_skip = skip_q; n_tsh = tsh_q; n_key = key_q; n_synth = synth_q;
		n_seen = seen_q;
		emit = 1'b0;
		j = '0;
		if (start_of_file) begin
			n_hidx = '0; n_mok = 1'b1; n_qt = '0; n_tempo = mnep_pkg::TEMPO_RESET;
			n_ph = PH_HEADER; n_delta = '0; n_st = '0; n_mt = '0; n_skip = '0;
			n_tsh = '0; n_key = '0; n_synth = '0; n_seen = 1'b0;
		end
		case (n_ph)
			PH_HEADER: begin
				if (n_hidx < 5'd4 && file_byte != mnep_pkg::magic_byte(n_hidx[1:0]))
					n_mok = 1'b0;
				if (n_hidx == 5'd12)
					n_qt = {file_byte, n_qt[7:0]};
				if (n_hidx == 5'd13)
					n_qt = {n_qt[15:8], file_byte};
				if (n_hidx == 5'd3 && !n_mok) begin
					emit = 1'b1;
					j.kind = 1'b1;
					n_ph = PH_DONE;
				end else if (n_hidx >= HDR_LAST) begin
					n_delta = '0;
					n_ph = PH_DELTA;
				end else begin
					n_hidx = n_hidx + 5'd1;
				end
			end
			PH_DELTA: begin
				n_delta = {n_delta[20:0], file_byte[6:0]};
				if (!file_byte[7])
					n_ph = PH_STATUS;
			end
			PH_STATUS: begin
				n_st = file_byte;
				if (file_byte == 8'hFF)
					n_ph = PH_META_TYPE;
				else if (file_byte[7:4] == 4'hC)
					n_ph = PH_PROGRAM;
				else if (file_byte[7:4] == 4'h9)
					n_ph = PH_NOTE_KEY;
				else if (file_byte[7:4] == 4'h8) begin
					n_skip = 8'd2;
					n_ph = PH_SKIP;
				end else begin
					n_delta = '0;
					n_ph = PH_DELTA;
				end
			end
			PH_META_TYPE: begin
				n_mt = file_byte;
				n_ph = PH_META_LEN;
			end
			PH_META_LEN: begin
				n_skip = file_byte;
				n_tsh = '0;
				if (file_byte == 8'd0) begin
					n_delta = '0;
					n_ph = PH_DELTA;
				end else begin
					n_ph = PH_META_D0;
				end
			end
			PH_META_D0, PH_META_D1, PH_META_D2, PH_SKIP: begin
				if (n_ph == PH_META_D0)
					n_tsh = 24'(file_byte);
				else if (n_ph == PH_META_D1 || n_ph == PH_META_D2)
					n_tsh = {n_tsh[15:0], file_byte};
				if (n_ph == PH_META_D2 && n_mt == 8'h51)
					n_tempo = n_tsh;
				n_skip = n_skip - 8'd1;
				if (n_skip == 8'd0) begin
					n_delta = '0;
					n_ph = PH_DELTA;
				end else if (n_ph == PH_META_D0) begin
					n_ph = PH_META_D1;
				end else if (n_ph == PH_META_D1) begin
					n_ph = PH_META_D2;
				end else begin
					n_ph = PH_SKIP;
				end
			end
			PH_PROGRAM: begin
				n_synth[n_st[3:0]] = (file_byte >= 8'd8 && file_byte <= 8'd95);
				n_delta = '0;
				n_ph = PH_DELTA;
			end
			PH_NOTE_KEY: begin
				n_key = file_byte;
				n_ph = PH_NOTE_VEL;
			end
			PH_NOTE_VEL: begin
				emit = 1'b1;
				j.channel = n_st[3:0];
				j.note_key = n_key;
				j.velocity = file_byte;
				if (n_st[3:0] == 4'd9)
					j.instrument = (n_key inside {8'd42, 8'd44, 8'd46}) ? 2'd2 : 2'd3;
				else
					j.instrument = n_synth[n_st[3:0]] ? 2'd1 : 2'd0;
				j.delta = n_delta;
				j.tempo = n_tempo;
				j.quarter = n_qt;
				j.seen = n_seen;
				n_seen = 1'b1;
				n_delta = '0;
				n_ph = PH_DELTA;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidx_q <= '0; mok_q <= 1'b1; qt_q <= '0; tempo_q <= mnep_pkg::TEMPO_RESET;
			ph_q <= PH_HEADER; delta_q <= '0; st_q <= '0; mt_q <= '0; skip_q <= '0;
			tsh_q <= '0; key_q <= '0; synth_q <= '0; seen_q <= 1'b0;
		end else if (accept) begin
			hidx_q <= n_hidx; mok_q <= n_mok; qt_q <= n_qt; tempo_q <= n_tempo;
			ph_q <= n_ph; delta_q <= n_delta; st_q <= n_st; mt_q <= n_mt;
			skip_q <= n_skip; tsh_q <= n_tsh; key_q <= n_key; synth_q <= n_synth;
			seen_q <= n_seen;
		end
	end

	assign job = j;
	assign push = accept && emit;
endmodule
`default_nettype wire

// ===== hdl/mnep_queue.sv =====
// Short job queue between the byte parser and the wait computation.
`timescale 1ns / 1ps
`default_nettype none
module mnep_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mnep_pkg::job_t wr_job,
	input  wire logic           pop,
	output mnep_pkg::job_t      rd_job,
	output mnep_pkg::queue_stat_t stat
);
	localparam int AW = $clog2(mnep_pkg::QUEUE_DEPTH);

	mnep_pkg::job_t mem_q [mnep_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(mnep_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(mnep_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rd_job = mem_q[rp_q];
	assign stat.full = (cnt_q == (AW+1)'(mnep_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
endmodule
`default_nettype wire

// ===== hdl/mnep_back.sv =====
// Wait computation with two multipliers and a bit-serial divider, plus the result register.
`timescale 1ns / 1ps
`default_nettype none
module mnep_back #(
	parameter int WAIT_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mnep_pkg::job_t   job,
	input  wire mnep_pkg::queue_stat_t stat,
	output logic                  pop,
	mnep_note_if.source           notes
);
	localparam int NW = 54;
	localparam int DW = 33;
	localparam int RW = (DW + WAIT_WIDTH > NW) ? DW + WAIT_WIDTH : NW;
	localparam int CW = $clog2(WAIT_WIDTH);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL = 3'd1;
	localparam logic [2:0] S_PREP = 3'd2;
	localparam logic [2:0] S_CHK = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	logic [2:0]            st_q;
	mnep_pkg::job_t        job_q;
	logic [51:0]           num_q;
	logic [31:0]           den_q;
	logic [RW-1:0]         rem_q;
	logic [RW-1:0]         dsh_q;
	logic [DW-1:0]         d_q;
	logic [WAIT_WIDTH-1:0] quo_q;
	logic [CW-1:0]         cnt_q;
	logic                  sat_q;
	logic                  ov_q;
	logic                  load;
	logic [WAIT_WIDTH-1:0] wait_v;

	assign pop = (st_q == S_IDLE) && !stat.empty;
	assign load = (st_q == S_FIN) && (!ov_q || notes.ready);
	assign wait_v = sat_q ? {WAIT_WIDTH{1'b1}} : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (load)
				ov_q <= 1'b1;
			else if (notes.ready)
				ov_q <= 1'b0;
			case (st_q)
				S_IDLE: if (pop) st_q <= S_MUL;
				S_MUL: st_q <= job_q.kind ? S_FIN : S_PREP;
				S_PREP: st_q <= S_CHK;
				S_CHK: st_q <= S_DIV;
				S_DIV: if (sat_q || cnt_q == '0) st_q <= S_FIN;
				S_FIN: if (load) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				job_q <= job;
				sat_q <= 1'b0;
			end
			S_MUL: begin
				num_q <= 52'(job_q.delta) * 52'(job_q.tempo);
				den_q <= 32'(job_q.quarter) * 32'(mnep_pkg::TICK_SCALE);
			end
			S_PREP: begin
				rem_q <= RW'({num_q, 1'b0}) + RW'(den_q);
				d_q <= {den_q, 1'b0};
			end
			S_CHK: begin
				sat_q <= (job_q.quarter == '0) || (rem_q >= (RW'(d_q) << WAIT_WIDTH));
				dsh_q <= RW'(d_q) << (WAIT_WIDTH - 1);
				cnt_q <= CW'(WAIT_WIDTH - 1);
				quo_q <= '0;
			end
			S_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[WAIT_WIDTH-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[WAIT_WIDTH-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (load) begin
			notes.kind <= job_q.kind;
			if (job_q.kind) begin
				notes.channel <= '0;
				notes.note_key <= '0;
				notes.velocity <= '0;
				notes.pitch_class <= '0;
				notes.octave <= '0;
				notes.instrument <= '0;
				notes.wait_ticks <= '0;
				notes.wait_saturated <= 1'b0;
				notes.joins_chord <= 1'b0;
			end else begin
				notes.channel <= job_q.channel;
				notes.note_key <= job_q.note_key;
				notes.velocity <= job_q.velocity;
				notes.pitch_class <= mnep_pkg::key_mod12(job_q.note_key);
				notes.octave <= $signed(6'(mnep_pkg::key_div12(job_q.note_key)) - 6'd1);
				notes.instrument <= job_q.instrument;
				notes.wait_ticks <= wait_v;
				notes.wait_saturated <= sat_q;
				notes.joins_chord <= job_q.seen && (wait_v == '0);
			end
		end
	end

	assign notes.valid = ov_q;
endmodule
`default_nettype wire

// ===== hdl/midi_note_event_parser_top.sv =====
// Top level of the MIDI note event parser: byte parser, job queue and wait unit.
// The parser takes one file byte per cycle while the two-entry job queue has room.
// A note-on job passes the wait unit's MUL, PREP, CHK, DIV and FIN states before its result is
// registered; the divider stops early when the wait saturates, and the unit takes no new job until then.
// A bad-magic result is issued on the fourth byte and goes from MUL straight to FIN.
// Reset returns all parse state to its initial values; start_of_file restarts the parse with the same values.
`timescale 1ns / 1ps
`default_nettype none
module midi_note_event_parser_top #(
	parameter int WAIT_WIDTH = 16
) (
	input wire logic    clk,
	input wire logic    arst_n,
	mnep_file_if.sink   file,
	mnep_note_if.source notes
);
	mnep_pkg::job_t        fr_job;
	mnep_pkg::job_t        hd_job;
	mnep_pkg::queue_stat_t q_stat;
	logic                  push;
	logic                  pop;
	logic                  accept;

	assign file.ready = !q_stat.full;
	assign accept = file.valid && file.ready;

	mnep_front u_front (
		.clk, .arst_n, .accept,
		.file_byte(file.file_byte), .start_of_file(file.start_of_file),
		.job(fr_job), .push
	);

	mnep_queue u_queue (
		.clk, .arst_n, .push, .wr_job(fr_job), .pop, .rd_job(hd_job), .stat(q_stat)
	);

	mnep_back #(.WAIT_WIDTH(WAIT_WIDTH)) u_back (
		.clk, .arst_n, .job(hd_job), .stat(q_stat), .pop, .notes
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full && !pop)) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty)) else $error("job queue underflow");
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		notes.valid && notes.wait_saturated |-> &notes.wait_ticks)
		else $error("saturated wait is not the maximum");
	a_chord_zero: assert property (@(posedge clk) disable iff (!arst_n)
		notes.valid && notes.joins_chord |-> notes.wait_ticks == '0)
		else $error("chord flag with nonzero wait");
endmodule
`default_nettype wire
